>>> hdl/ccye_pkg.sv
// Shared types and constants for the conic curve y evaluator.
// No dependencies.
package ccye_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [1:0] {
      KIND_LINE      = 2'd0,
      KIND_ELLIPSE   = 2'd1,
      KIND_HYPERBOLA = 2'd2
   } curve_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DOMAIN = 2'd1,
      STATUS_SAT    = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KIND   = 2'd0,
      CSR_COEF_A = 2'd1,
      CSR_COEF_B = 2'd2
   } csr_index_type;

   // control that rides along with every word in the pipe
   typedef struct packed {
      logic vld;
      logic is_line;
      logic ell;
      logic err;
      logic neg;
   } ctl_type;

endpackage

>>> hdl/ccye_if.sv
// Valid/ready channel interfaces for x words in and y words out.
// Has no dependencies; the status field is a plain two-bit vector.
interface ccye_req_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] x_value;
   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

interface ccye_rsp_if #(parameter int W = 32);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] y_value;
   logic [1:0]          status;
   modport source (output valid, output y_value, output status, input ready);
   modport sink   (input valid, input y_value, input status, output ready);
endinterface

>>> hdl/ccye_front.sv
// Front pipeline: magnitudes, squares, line sum and the radicand B^2*(A^2-X^2) or B^2*(X^2-A^2).
// Depends on ccye_pkg.
module ccye_front import ccye_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF,
   parameter int F = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [W-1:0]      x_in,
   input  logic [1:0]        kind,
   input  logic [W-1:0]      coef_a,
   input  logic [W-1:0]      coef_b,
   output ctl_type           ctl_out,
   output logic [4*W-1:0]    n_out,
   output logic [2*W-1:0]    t_out,
   output logic [2*W:0]      lmag_out
);

   localparam logic [W-1:0] ZERO_W = '0;

   logic [W-1:0] ma, mb, mx;
   logic         na, nb, nx;

   assign na = coef_a[W-1];
   assign nb = coef_b[W-1];
   assign nx = x_in[W-1];
   assign ma = na ? (ZERO_W - coef_a) : coef_a;
   assign mb = nb ? (ZERO_W - coef_b) : coef_b;
   assign mx = nx ? (ZERO_W - x_in) : x_in;

   // stage 0
   ctl_type      s0_ctl_ff, s0_ctl_in;
   logic         s0_np_ff;
   logic [W-1:0] s0_ma_ff, s0_mb_ff, s0_mx_ff;

   always_comb begin
      s0_ctl_in.vld     = in_vld;
      s0_ctl_in.is_line = (kind == KIND_LINE);
      s0_ctl_in.ell     = (kind == KIND_ELLIPSE);
      s0_ctl_in.neg     = nb;
      s0_ctl_in.err     = (kind != KIND_ELLIPSE && kind != KIND_HYPERBOLA)
                          || (ma == ZERO_W)
                          || (kind == KIND_ELLIPSE && mx > ma)
                          || (kind == KIND_HYPERBOLA && mx < ma);
   end

   // stage 1: products
   ctl_type        s1_ctl_ff;
   logic           s1_np_ff;
   logic [2*W-1:0] s1_p_ff, s1_q_ff, s1_aa_ff, s1_xx_ff, s1_bb_ff;

   // stage 2: line add/sub, conic difference
   ctl_type        s2_ctl_ff, s2_ctl_in;
   logic [2*W:0]   s2_lmag_ff, s2_lmag_in;
   logic [2*W-1:0] s2_d_ff, s2_d_in, s2_t_ff, s2_bb_ff;
   logic [2*W:0]   lsum;
   logic           lneg;

   always_comb begin
      lneg = s1_np_ff;
      if (s1_np_ff == s1_ctl_ff.neg) begin
         lsum = {1'b0, s1_p_ff} + {1'b0, s1_q_ff};
      end else if (s1_p_ff >= s1_q_ff) begin
         lsum = {1'b0, s1_p_ff - s1_q_ff};
      end else begin
         lsum = {1'b0, s1_q_ff - s1_p_ff};
         lneg = s1_ctl_ff.neg;
      end
      s2_lmag_in = lsum >> F;
      s2_d_in    = s1_ctl_ff.ell ? (s1_aa_ff - s1_xx_ff) : (s1_xx_ff - s1_aa_ff);
      s2_ctl_in  = s1_ctl_ff;
      if (s1_ctl_ff.is_line) begin
         s2_ctl_in.neg = lneg;
      end
   end

   // stage 3: partial products of B^2 * D
   ctl_type        s3_ctl_ff;
   logic [2*W:0]   s3_lmag_ff;
   logic [2*W-1:0] s3_t_ff, s3_pp0_ff, s3_pp1_ff, s3_pp2_ff, s3_pp3_ff;

   // stage 4: radicand
   ctl_type        s4_ctl_ff;
   logic [2*W:0]   s4_lmag_ff;
   logic [2*W-1:0] s4_t_ff;
   logic [4*W-1:0] s4_n_ff, s4_n_in;

   assign s4_n_in = (4*W)'(s3_pp0_ff)
                  + ((4*W)'(s3_pp1_ff) << W)
                  + ((4*W)'(s3_pp2_ff) << W)
                  + ((4*W)'(s3_pp3_ff) << (2*W));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff.vld <= 1'b0;
         s1_ctl_ff.vld <= 1'b0;
         s2_ctl_ff.vld <= 1'b0;
         s3_ctl_ff.vld <= 1'b0;
         s4_ctl_ff.vld <= 1'b0;
      end else if (adv) begin
         s0_ctl_ff.vld <= s0_ctl_in.vld;
         s1_ctl_ff.vld <= s0_ctl_ff.vld;
         s2_ctl_ff.vld <= s2_ctl_in.vld;
         s3_ctl_ff.vld <= s2_ctl_ff.vld;
         s4_ctl_ff.vld <= s3_ctl_ff.vld;
      end
      if (adv) begin
         {s0_ctl_ff.is_line, s0_ctl_ff.ell, s0_ctl_ff.err, s0_ctl_ff.neg} <=
            {s0_ctl_in.is_line, s0_ctl_in.ell, s0_ctl_in.err, s0_ctl_in.neg};
         s0_np_ff <= na ^ nx;
         s0_ma_ff <= ma;
         s0_mb_ff <= mb;
         s0_mx_ff <= mx;

         {s1_ctl_ff.is_line, s1_ctl_ff.ell, s1_ctl_ff.err, s1_ctl_ff.neg} <=
            {s0_ctl_ff.is_line, s0_ctl_ff.ell, s0_ctl_ff.err, s0_ctl_ff.neg};
         s1_np_ff <= s0_np_ff;
         s1_p_ff  <= (2*W)'(s0_ma_ff) * (2*W)'(s0_mx_ff);
         s1_q_ff  <= (2*W)'(s0_mb_ff) << F;
         s1_aa_ff <= (2*W)'(s0_ma_ff) * (2*W)'(s0_ma_ff);
         s1_xx_ff <= (2*W)'(s0_mx_ff) * (2*W)'(s0_mx_ff);
         s1_bb_ff <= (2*W)'(s0_mb_ff) * (2*W)'(s0_mb_ff);

         {s2_ctl_ff.is_line, s2_ctl_ff.ell, s2_ctl_ff.err, s2_ctl_ff.neg} <=
            {s2_ctl_in.is_line, s2_ctl_in.ell, s2_ctl_in.err, s2_ctl_in.neg};
         s2_lmag_ff <= s2_lmag_in;
         s2_d_ff    <= s2_d_in;
         s2_t_ff    <= s1_aa_ff;
         s2_bb_ff   <= s1_bb_ff;

         {s3_ctl_ff.is_line, s3_ctl_ff.ell, s3_ctl_ff.err, s3_ctl_ff.neg} <=
            {s2_ctl_ff.is_line, s2_ctl_ff.ell, s2_ctl_ff.err, s2_ctl_ff.neg};
         s3_lmag_ff <= s2_lmag_ff;
         s3_t_ff    <= s2_t_ff;
         s3_pp0_ff  <= (2*W)'(s2_bb_ff[W-1:0])   * (2*W)'(s2_d_ff[W-1:0]);
         s3_pp1_ff  <= (2*W)'(s2_bb_ff[W-1:0])   * (2*W)'(s2_d_ff[2*W-1:W]);
         s3_pp2_ff  <= (2*W)'(s2_bb_ff[2*W-1:W]) * (2*W)'(s2_d_ff[W-1:0]);
         s3_pp3_ff  <= (2*W)'(s2_bb_ff[2*W-1:W]) * (2*W)'(s2_d_ff[2*W-1:W]);

         {s4_ctl_ff.is_line, s4_ctl_ff.ell, s4_ctl_ff.err, s4_ctl_ff.neg} <=
            {s3_ctl_ff.is_line, s3_ctl_ff.ell, s3_ctl_ff.err, s3_ctl_ff.neg};
         s4_lmag_ff <= s3_lmag_ff;
         s4_t_ff    <= s3_t_ff;
         s4_n_ff    <= s4_n_in;
      end
   end

   assign ctl_out  = s4_ctl_ff;
   assign n_out    = s4_n_ff;
   assign t_out    = s4_t_ff;
   assign lmag_out = s4_lmag_ff;

endmodule

>>> hdl/ccye_cell.sv
// One cell of the root-quotient chain: settles one bit of y = max{y : y^2*A^2 <= N}.
// Depends on ccye_pkg.
module ccye_cell import ccye_pkg::*; #(
   parameter int W = DATA_WIDTH_DEF,
   parameter int K = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  ctl_type        ctl_in,
   input  logic [4*W-1:0] r_in,
   input  logic [3*W-1:0] p_in,
   input  logic [2*W-1:0] t_in,
   input  logic [W-1:0]   acc_in,
   input  logic [2*W:0]   lmag_in,
   output ctl_type        ctl_out,
   output logic [4*W-1:0] r_out,
   output logic [3*W-1:0] p_out,
   output logic [2*W-1:0] t_out,
   output logic [W-1:0]   acc_out,
   output logic [2*W:0]   lmag_out
);

   // r = N - acc^2*T, p = acc*T; adding bit K costs (p << K+1) + (T << 2K)
   logic [4*W:0]   trial;
   logic           take;
   ctl_type        ctl_ff;
   logic [4*W-1:0] r_ff, r_in_nxt;
   logic [3*W-1:0] p_ff, p_in_nxt;
   logic [2*W-1:0] t_ff;
   logic [W-1:0]   acc_ff, acc_in_nxt;
   logic [2*W:0]   lmag_ff;

   always_comb begin
      trial      = ((4*W+1)'(p_in) << (K + 1)) + ((4*W+1)'(t_in) << (2 * K));
      take       = ({1'b0, r_in} >= trial);
      r_in_nxt   = take ? (r_in - trial[4*W-1:0]) : r_in;
      p_in_nxt   = take ? (p_in + ((3*W)'(t_in) << K)) : p_in;
      acc_in_nxt = take ? (acc_in | (W'(1) << K)) : acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.vld <= 1'b0;
      end else if (adv) begin
         ctl_ff.vld <= ctl_in.vld;
      end
      if (adv) begin
         {ctl_ff.is_line, ctl_ff.ell, ctl_ff.err, ctl_ff.neg} <=
            {ctl_in.is_line, ctl_in.ell, ctl_in.err, ctl_in.neg};
         r_ff    <= r_in_nxt;
         p_ff    <= p_in_nxt;
         t_ff    <= t_in;
         acc_ff  <= acc_in_nxt;
         lmag_ff <= lmag_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign r_out    = r_ff;
   assign p_out    = p_ff;
   assign t_out    = t_ff;
   assign acc_out  = acc_ff;
   assign lmag_out = lmag_ff;

endmodule

>>> hdl/conic_curve_y_evaluator.sv
// Top level of the conic curve y evaluator: config registers, front pipe,
// chain of bit cells and the saturating output register. Uses ccye_pkg, ccye_if,
// ccye_front and ccye_cell.
//
//   channel   dir  word                          handshake
//   req_bus   in   x_value (signed Q16.16)       valid/ready
//   rsp_bus   out  y_value (signed), status(2)   valid/ready
//   csr_*     in   index 0 kind, 1 a, 2 b        csr_wen, no back-pressure
//
// One x word per clock while rsp_bus is not stalled. A word passes five front stages,
// one cell per result bit and the output register; the cell chain is fully pipelined,
// one radicand bit-pair step per cell.
// The whole pipe advances when the output register is empty or being drained;
// a stalled rsp_bus freezes every stage and drops req_bus.ready.
// Synchronous reset clears the valid bits and loads kind=line, a=1.0, b=0.
module conic_curve_y_evaluator import ccye_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   ccye_req_if.sink                  req_bus,
   ccye_rsp_if.source                rsp_bus,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]     csr_wdata
);

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0]  A_RESET = W'(1) << FRAC_BITS;
   localparam logic [2*W:0]  LIM_POS = ((2*W+1)'(1) << (W - 1)) - (2*W+1)'(1);
   localparam logic [2*W:0]  LIM_NEG = (2*W+1)'(1) << (W - 1);
   localparam logic [W-1:0]  Y_MAX   = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  Y_MIN   = {1'b1, {(W-1){1'b0}}};

   // configuration registers
   logic [1:0]   kind_ff;
   logic [W-1:0] coef_a_ff, coef_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_LINE;
         coef_a_ff <= A_RESET;
         coef_b_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_KIND:   kind_ff   <= csr_wdata[1:0];
            CSR_COEF_A: coef_a_ff <= csr_wdata;
            CSR_COEF_B: coef_b_ff <= csr_wdata;
            default:    ;  // index 3 is not a register
         endcase
      end
   end

   // global advance: output register empty or draining
   logic rsp_vld_ff;
   logic adv;
   assign adv           = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // front pipe
   ctl_type        f_ctl;
   logic [4*W-1:0] f_n;
   logic [2*W-1:0] f_t;
   logic [2*W:0]   f_lmag;

   ccye_front #(.W(W), .F(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_bus.valid),
      .x_in     (req_bus.x_value),
      .kind     (kind_ff),
      .coef_a   (coef_a_ff),
      .coef_b   (coef_b_ff),
      .ctl_out  (f_ctl),
      .n_out    (f_n),
      .t_out    (f_t),
      .lmag_out (f_lmag)
   );

   // cell chain, cell i settles bit W-1-i of |y|
   ctl_type        c_ctl  [0:W];
   logic [4*W-1:0] c_r    [0:W];
   logic [3*W-1:0] c_p    [0:W];
   logic [2*W-1:0] c_t    [0:W];
   logic [W-1:0]   c_acc  [0:W];
   logic [2*W:0]   c_lmag [0:W];

   assign c_ctl[0]  = f_ctl;
   assign c_r[0]    = f_n;
   assign c_p[0]    = '0;
   assign c_t[0]    = f_t;
   assign c_acc[0]  = '0;
   assign c_lmag[0] = f_lmag;

   for (genvar i = 0; i < W; i++) begin : g_cell
      ccye_cell #(.W(W), .K(W - 1 - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_in   (c_ctl[i]),
         .r_in     (c_r[i]),
         .p_in     (c_p[i]),
         .t_in     (c_t[i]),
         .acc_in   (c_acc[i]),
         .lmag_in  (c_lmag[i]),
         .ctl_out  (c_ctl[i+1]),
         .r_out    (c_r[i+1]),
         .p_out    (c_p[i+1]),
         .t_out    (c_t[i+1]),
         .acc_out  (c_acc[i+1]),
         .lmag_out (c_lmag[i+1])
      );
   end

   // finish: domain error, saturation, sign
   ctl_type      last;
   logic [2*W:0] mag;
   logic [W-1:0] y_in;
   logic [1:0]   status_in;
   logic [W-1:0] y_ff;
   logic [1:0]   status_ff;

   assign last = c_ctl[W];

   always_comb begin
      mag = last.is_line ? c_lmag[W] : (2*W+1)'(c_acc[W]);
      priority if (!last.is_line && last.err) begin
         y_in      = '0;
         status_in = STATUS_DOMAIN;
      end else if (mag > (last.neg ? LIM_NEG : LIM_POS)) begin
         y_in      = last.neg ? Y_MIN : Y_MAX;
         status_in = STATUS_SAT;
      end else begin
         y_in      = last.neg ? (W'(0) - mag[W-1:0]) : mag[W-1:0];
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff      <= y_in;
         status_ff <= status_in;
      end
   end

   assign rsp_bus.valid   = rsp_vld_ff;
   assign rsp_bus.y_value = y_ff;
   assign rsp_bus.status  = status_ff;

   // a domain error always carries y = 0
   a_domain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && status_ff == STATUS_DOMAIN |-> y_ff == '0)
      else $error("domain error with nonzero y");

   // saturation only ever reports an end code
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && status_ff == STATUS_SAT |-> (y_ff == Y_MAX || y_ff == Y_MIN))
      else $error("saturated y not at a rail");

   // a stall freezes the end of the cell chain
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(c_acc[W]) && $stable(c_ctl[W]))
      else $error("cell chain moved during stall");

   // an entering word that meets no stall leaves the front with its valid bit set
   a_front_lat: assert property (@(posedge clock) disable iff (reset)
      adv && req_bus.valid ##1 adv ##1 adv ##1 adv ##1 adv |=> f_ctl.vld)
      else $error("front pipe lost a word");

endmodule

>>> verif/tb_conic_curve_y_evaluator.sv
// Self-checking bench for conic_curve_y_evaluator: directed table, then random phases.
// Depends on ccye_pkg, the ccye_req_if/ccye_rsp_if interfaces and the block's RTL.
module tb_conic_curve_y_evaluator;
   import ccye_pkg::*;

   localparam int                        W           = 32;
   localparam logic [1:0]                KIND_UNUSED = 2'd3;   // no curve behind this code
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED  = 2'd3;   // index past coef_b
   localparam logic signed [W-1:0]       ONE         = 32'sh0001_0000;
   localparam logic signed [W-1:0]       DMAX        = 32'sh7fff_ffff;
   localparam logic signed [W-1:0]       DMIN        = 32'sh8000_0000;
   localparam longint                    HALF_RANGE  = 64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [W-1:0] csr_wdata = '0;
   logic quiet = 1'b0;   // set during the stretch with no idling on either side

   always #5 clock = ~clock;

   ccye_req_if #(W) req_bus ();
   ccye_rsp_if #(W) rsp_bus ();

   conic_curve_y_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   typedef struct {
      logic signed [W-1:0] y;
      status_type          st;
   } curve_point;

   // bench copy of the curve registers
   logic [1:0]          cur_kind = KIND_LINE;
   logic signed [W-1:0] cur_a    = ONE;
   logic signed [W-1:0] cur_b    = '0;

   curve_point y_pending[$];
   int errors = 0, words_sent = 0, words_checked = 0, phases = 0;

   function automatic longint abs_code(input logic signed [W-1:0] v);
      return (v < 0) ? -longint'(v) : longint'(v);
   endfunction

   function automatic logic [63:0] isqrt(input logic [127:0] n);
      logic [63:0] acc, c;
      acc = '0;
      for (int i = 63; i >= 0; i--) begin
         c = acc | (64'd1 << i);
         if (128'(c) * 128'(c) <= n) acc = c;
      end
      return acc;
   endfunction

   // exact y for one x, truncated toward zero, saturated to the word range
   function automatic curve_point eval_curve(input logic [1:0] kind,
         input logic signed [W-1:0] a, input logic signed [W-1:0] b,
         input logic signed [W-1:0] x);
      curve_point r;
      logic signed [127:0] lin;
      logic [127:0] rad, q;
      longint ma, mb, mx;
      ma = abs_code(a);
      mb = abs_code(b);
      mx = abs_code(x);
      r.st = STATUS_OK;
      if (kind == KIND_LINE) begin
         lin = 128'(a) * 128'(x) + 128'(b) * 128'sd65536;
         lin = lin / 128'sd65536;   // SV divide truncates toward zero
         if (lin > 128'(DMAX)) begin r.y = DMAX; r.st = STATUS_SAT; end
         else if (lin < 128'(DMIN)) begin r.y = DMIN; r.st = STATUS_SAT; end
         else r.y = lin[W-1:0];
         return r;
      end
      if (kind == KIND_UNUSED || ma == 0 || (kind == KIND_ELLIPSE && mx > ma) ||
          (kind == KIND_HYPERBOLA && mx < ma)) begin
         r.y = '0;
         r.st = STATUS_DOMAIN;
         return r;
      end
      if (kind == KIND_ELLIPSE)
         rad = 128'(mb) * 128'(mb) * (128'(ma) * 128'(ma) - 128'(mx) * 128'(mx));
      else
         rad = 128'(mb) * 128'(mb) * (128'(mx) * 128'(mx) - 128'(ma) * 128'(ma));
      q = 128'(isqrt(rad)) / 128'(ma);
      if (b < 0) begin
         if (q > 128'(HALF_RANGE)) begin r.y = DMIN; r.st = STATUS_SAT; end
         else r.y = -q[W-1:0];
      end else begin
         if (q > 128'(HALF_RANGE - 1)) begin r.y = DMAX; r.st = STATUS_SAT; end
         else r.y = q[W-1:0];
      end
      return r;
   endfunction

   // wait out every word in flight, then the pipe depth before touching a register
   task automatic drain_pipe();
      while (y_pending.size() != 0) @(posedge clock);
      repeat (6 + W + 4) @(posedge clock);
   endtask

   // one write, then csr_wen is dropped and held low so back-to-back writes never stack on one edge
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_KIND:   cur_kind = val[1:0];
         CSR_COEF_A: cur_a = val;
         CSR_COEF_B: cur_b = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one x word through the handshake; the prediction is queued at acceptance
   task automatic send_x(input logic signed [W-1:0] x);
      while (!quiet && $urandom_range(0, 99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.x_value <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      y_pending.push_back(eval_curve(cur_kind, cur_a, cur_b, x));
      words_sent++;
   endtask

   // result side: random back-pressure, compare against the oldest prediction
   initial rsp_bus.ready = 1'b0;
   always @(posedge clock) rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 14);

   always @(posedge clock) begin
      curve_point e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (y_pending.size() == 0) begin
            $display("%0t: unexpected word y=%h status=%0d", $time, rsp_bus.y_value,
                     rsp_bus.status);
            errors++;
         end else begin
            e = y_pending.pop_front();
            words_checked++;
            if (rsp_bus.y_value !== e.y) begin
               $display("%0t: y_value mismatch expected %h actual %h", $time, e.y,
                        rsp_bus.y_value);
               errors++;
            end
            if (rsp_bus.status !== e.st) begin
               $display("%0t: status mismatch expected %0d actual %0d", $time, e.st,
                        rsp_bus.status);
               errors++;
            end
         end
      end
   end

   // directed rows: curve setup, x, and a typed answer where it is obvious
   typedef struct {
      logic [1:0]          kind;
      logic signed [W-1:0] a, b, x;
      bit                  typed;
      logic signed [W-1:0] y;
      status_type          st;
   } curve_row;

   curve_row rows[] = '{
      // reset setup: y = x
      '{KIND_LINE, ONE, 0, 32'sh0005_0000, 1, 32'sh0005_0000, STATUS_OK},
      '{KIND_LINE, ONE, 0, DMAX, 1, DMAX, STATUS_OK},
      '{KIND_LINE, ONE, 0, DMIN, 1, DMIN, STATUS_OK},
      // line overflow both ways, then mixed-sign rows in range
      '{KIND_LINE, DMAX, DMAX, DMAX, 1, DMAX, STATUS_SAT},
      '{KIND_LINE, DMAX, DMIN, DMIN, 1, DMIN, STATUS_SAT},
      '{KIND_LINE, -ONE, 32'sh0002_0000, 32'sh0003_0000, 0, 0, STATUS_OK},
      '{KIND_LINE, 32'sh0000_0001, -32'sh0000_0001, 32'sh0000_7fff, 0, 0, STATUS_OK},
      // ellipse: center, both rims, just outside the rim, off-center, zero axis, extremes
      '{KIND_ELLIPSE, 32'sh0002_0000, 32'sh0003_0000, 0, 1, 32'sh0003_0000, STATUS_OK},
      '{KIND_ELLIPSE, 32'sh0002_0000, 32'sh0003_0000, 32'sh0002_0000, 1, 0, STATUS_OK},
      '{KIND_ELLIPSE, 32'sh0002_0000, 32'sh0003_0000, -32'sh0002_0000, 1, 0, STATUS_OK},
      '{KIND_ELLIPSE, 32'sh0002_0000, 32'sh0003_0000, 32'sh0002_0001, 1, 0, STATUS_DOMAIN},
      '{KIND_ELLIPSE, 32'sh0002_0000, -32'sh0003_0000, ONE, 0, 0, STATUS_OK},
      '{KIND_ELLIPSE, 0, 32'sh0003_0000, 0, 1, 0, STATUS_DOMAIN},
      '{KIND_ELLIPSE, DMIN, DMIN, 0, 0, 0, STATUS_OK},
      '{KIND_ELLIPSE, DMAX, DMAX, 0, 0, 0, STATUS_OK},
      '{KIND_ELLIPSE, DMIN, DMAX, DMIN, 0, 0, STATUS_OK},
      // hyperbola: inside the gap, vertex, far branches, zero axis, overflow
      '{KIND_HYPERBOLA, ONE, ONE, 32'sh0000_8000, 1, 0, STATUS_DOMAIN},
      '{KIND_HYPERBOLA, ONE, ONE, ONE, 1, 0, STATUS_OK},
      '{KIND_HYPERBOLA, ONE, ONE, DMAX, 0, 0, STATUS_OK},
      '{KIND_HYPERBOLA, ONE, -ONE, DMIN, 0, 0, STATUS_OK},
      '{KIND_HYPERBOLA, 0, ONE, ONE, 1, 0, STATUS_DOMAIN},
      '{KIND_HYPERBOLA, 32'sh0000_0001, DMAX, DMAX, 0, 0, STATUS_OK},
      '{KIND_HYPERBOLA, 32'sh0000_0001, DMIN, DMAX, 0, 0, STATUS_OK},
      // code 3 has no curve
      '{KIND_UNUSED, ONE, ONE, ONE, 1, 0, STATUS_DOMAIN}
   };

   function automatic logic signed [W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return DMIN;
         1: return DMAX;
         2: return '0;
         3: return ONE;
         default: return ($urandom_range(0, 1) ? -1 : 1) *
                         signed'(W'($urandom >> $urandom_range(1, 31)));
      endcase
   endfunction

   // x inside the ellipse or outside the hyperbola gap, mostly
   function automatic logic signed [W-1:0] pick_x();
      longint ma, mx;
      bit neg;
      ma = abs_code(cur_a);
      if ($urandom_range(0, 9) == 0 || cur_kind == KIND_LINE || cur_kind == KIND_UNUSED)
         return $urandom;
      if (cur_kind == KIND_ELLIPSE)
         mx = longint'($urandom) % (ma + 1);
      else
         mx = ma + (longint'($urandom) >> $urandom_range(0, 31));
      if (mx > HALF_RANGE) mx = HALF_RANGE;
      neg = $urandom_range(0, 1);
      if (!neg && mx > HALF_RANGE - 1) mx = HALF_RANGE - 1;
      return neg ? W'(-mx) : W'(mx);
   endfunction

   initial begin
      logic [1:0] k;
      req_bus.valid   <= 1'b0;
      req_bus.x_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; rows with a typed answer also check the predictor
      foreach (rows[i]) begin
         if (rows[i].kind != cur_kind || rows[i].a != cur_a || rows[i].b != cur_b) begin
            req_bus.valid <= 1'b0;
            drain_pipe();
            if (rows[i].kind != cur_kind) write_csr(CSR_KIND, W'(rows[i].kind));
            if (rows[i].a != cur_a) write_csr(CSR_COEF_A, rows[i].a);
            if (rows[i].b != cur_b) write_csr(CSR_COEF_B, rows[i].b);
         end
         if (rows[i].typed) begin
            curve_point p;
            p = eval_curve(rows[i].kind, rows[i].a, rows[i].b, rows[i].x);
            if (p.y !== rows[i].y || p.st !== rows[i].st) begin
               $display("%0t: row %0d predictor expected %h/%0d actual %h/%0d", $time, i,
                        rows[i].y, rows[i].st, p.y, p.st);
               errors++;
            end
         end
         send_x(rows[i].x);
      end

      // a write past coef_b must leave the curve alone
      req_bus.valid <= 1'b0;
      drain_pipe();
      write_csr(CSR_UNUSED, 32'hffff_ffff);
      send_x(ONE);

      // random phases, each with a fresh curve
      for (int p = 0; p < 13; p++) begin
         req_bus.valid <= 1'b0;
         drain_pipe();
         quiet = (p == 6);
         k = $urandom_range(0, 9);
         k = (k < 3) ? KIND_LINE : (k < 6) ? KIND_ELLIPSE : (k < 9) ? KIND_HYPERBOLA
                                                                      : KIND_UNUSED;
         write_csr(CSR_KIND, W'(k));
         write_csr(CSR_COEF_A, pick_coef());
         write_csr(CSR_COEF_B, pick_coef());
         phases++;
         for (int n = 0; n < 100; n++) send_x(pick_x());
      end
      req_bus.valid <= 1'b0;
      quiet = 1'b0;

      while (y_pending.size() != 0) @(posedge clock);
      repeat (6 + W + 4) @(posedge clock);
      $display("Sent %0d x words (directed table plus %0d random curve setups), checked %0d.",
               words_sent, phases, words_checked);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d words outstanding", y_pending.size());
      $display("Verification failed");
      $finish;
   end

endmodule

>>> conic_curve_y_evaluator.f
hdl/ccye_pkg.sv
hdl/ccye_if.sv
hdl/ccye_front.sv
hdl/ccye_cell.sv
hdl/conic_curve_y_evaluator.sv
verif/tb_conic_curve_y_evaluator.sv
